/* sv/sidta_pkg.sv */
// Shared types, constants and helpers for the signed integer to decimal ASCII block.
package sidta_pkg;

  localparam int unsigned MagW   = 32;
  localparam int unsigned DigitN = 10;
  localparam int unsigned BcdW   = 4 * DigitN;
  localparam int unsigned CntW   = $clog2(MagW);
  localparam int unsigned IdxW   = $clog2(DigitN);

  localparam logic [CntW-1:0] CntLast   = CntW'(MagW - 1);
  localparam logic [7:0]      CharMinus = 8'd45;
  localparam logic [7:0]      CharZero  = 8'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_PREP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic prep;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic emit_last;
    logic out_free;
  } dp_sts_t;

  // Index of the most significant nonzero digit, zero when all digits are zero.
  function automatic logic [IdxW-1:0] lead_digit(input logic [BcdW-1:0] bcd);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = 0; i < DigitN; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

  // One double-dabble step: correct each digit, then shift the whole word left.
  function automatic logic [BcdW+MagW-1:0] dabble_step(input logic [BcdW-1:0] bcd,
                                                       input logic [MagW-1:0] mag);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DigitN; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], mag, 1'b0};
  endfunction

endpackage

/* sv/sidta_datapath.sv */
// Datapath: magnitude and BCD registers, digit pointer and output register.
module sidta_datapath
  import sidta_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic signed [31:0] value_i,
  input  logic              stall_i,
  output logic              valid_o,
  output logic [7:0]        ascii_char_o,
  output logic              last_char_o
);

  logic [MagW-1:0] mag_q, mag_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic            sign_pend_q, sign_pend_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      char_q, char_d;
  logic            last_q, last_d;

  logic [MagW-1:0]      raw;
  logic [BcdW+MagW-1:0] step;
  logic [3:0]           cur_digit;

  assign raw       = MagW'(unsigned'(value_i));
  assign step      = dabble_step(bcd_q, mag_q);
  assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];

  assign sts_o.conv_done = (cnt_q == CntLast);
  assign sts_o.emit_last = !sign_pend_q && (idx_q == '0);
  assign sts_o.out_free  = !out_valid_q || !stall_i;

  always_comb begin
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    sign_pend_d = sign_pend_q;
    idx_d       = idx_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && stall_i;

    if (cmd_i.load) begin
      neg_d = raw[MagW-1];
      mag_d = raw[MagW-1] ? (~raw + MagW'(1)) : raw;
      bcd_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.shift) begin
      {bcd_d, mag_d} = step;
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd_i.prep) begin
      idx_d       = lead_digit(bcd_q);
      sign_pend_d = neg_q;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      if (sign_pend_q) begin
        char_d      = CharMinus;
        last_d      = 1'b0;
        sign_pend_d = 1'b0;
      end else begin
        char_d = CharZero + {4'd0, cur_digit};
        last_d = (idx_q == '0);
        idx_d  = idx_q - IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      sign_pend_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      sign_pend_q <= sign_pend_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign valid_o      = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

`ifndef ASSERT_OFF
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (cnt_q == '0) && (bcd_q == '0))
    else $error("conversion did not restart cleanly after load");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("character emitted over an untaken output");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (char_q == CharMinus) || ((char_q >= CharZero) && (char_q <= 8'd57)))
    else $error("output character is neither a digit nor a minus sign");

  a_digit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !sign_pend_q) |-> (idx_q < IdxW'(DigitN)))
    else $error("digit pointer beyond the BCD word");
`endif

endmodule

/* sv/sidta_ctrl.sv */
// Controller: sequences load, conversion steps, digit search and character output.
module sidta_ctrl
  import sidta_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    stall_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (valid_i) state_d = ST_CONVERT;
      ST_CONVERT: if (sts_i.conv_done) state_d = ST_PREP;
      ST_PREP:    state_d = ST_EMIT;
      ST_EMIT:    if (sts_i.out_free && sts_i.emit_last) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        stall_o    = 1'b0;
        cmd_o.load = valid_i;
      end
      ST_CONVERT: cmd_o.shift = 1'b1;
      ST_PREP:    cmd_o.prep  = 1'b1;
      ST_EMIT:    cmd_o.emit  = sts_i.out_free;
      default:    cmd_o       = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/signed_int_to_decimal_ascii_top.sv */
// Top level: signed 32-bit integer to decimal ASCII text converter.
//
// Input channel: value_i with valid_i; a transaction completes when valid_i is
// high and stall_o is low. stall_o stays high from acceptance until the last
// character of that number has been placed in the output register.
// Output channel: ascii_char_o and last_char_o with valid_o; a transaction
// completes when valid_o is high and stall_i is low. Each number gives an
// optional '-' followed by its digits, most significant first, with no leading
// zeros; last_char_o marks the final character.
// Timing: the magnitude runs through 32 double-dabble steps (one per cycle),
// the ST_PREP state then finds the leading digit, then one character per cycle
// enters the output register while the receiver does not stall. An item of n
// characters has n in the range 1..11.
// Stalls: a stalled character holds in the output register and the next one
// waits behind it; the next input is taken once the last character is loaded.
// Reset: returns to idle and drops any pending output character.
module signed_int_to_decimal_ascii_top
  import sidta_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] value_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [7:0]         ascii_char_o,
  output logic               last_char_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sidta_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  sidta_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .stall_i      (stall_i),
    .valid_o      (valid_o),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

endmodule

/* tb/sv/tb.sv */
// Testbench for the signed integer to decimal ASCII converter: self-checking, randomized.
module tb
  import sidta_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               valid_i = 1'b0;
  logic signed [31:0] value_i = '0;
  logic               stall_i = 1'b0;
  logic               stall_o;
  logic               valid_o;
  logic [7:0]         ascii_char_o;
  logic               last_char_o;

  text_char_t pending_chars[$];
  int         mismatch_cnt  = 0;
  rx_mode_e   rx_mode       = RX_FREE;
  int         hold_req      = 0;
  bit         tx_gaps       = 1'b0;
  int         tx_max_gap    = 8;
  int         burst_left    = 0;

  signed_int_to_decimal_ascii_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .ascii_char_o(ascii_char_o),
    .last_char_o (last_char_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin : watchdog
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  // Expected text of one value: optional minus, then digits, most significant first.
  function automatic void push_decimal_text(input logic [31:0] raw);
    logic [31:0] mag;
    logic [3:0]  digit[DigitN];
    int          nd;
    text_char_t  c;
    mag = raw[31] ? (32'd0 - raw) : raw;
    nd  = 0;
    do begin
      digit[nd] = 4'(mag % 32'd10);
      mag       = mag / 32'd10;
      nd++;
    end while (mag != 0 && nd < DigitN);
    if (raw[31]) begin
      c.ch   = CharMinus;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.ch   = CharZero + 8'(digit[k]);
      c.last = (k == 0);
      pending_chars.push_back(c);
    end
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Check every character transaction against the oldest expectation.
  always @(posedge clk_i) begin : check_output
    text_char_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected char %0d last %0b", ascii_char_o, last_char_o));
      end else begin
        want = pending_chars.pop_front();
        if (ascii_char_o !== want.ch) begin
          note_mismatch($sformatf("char exp %0d got %0d", want.ch, ascii_char_o));
        end
        if (last_char_o !== want.last) begin
          note_mismatch($sformatf("last exp %0b got %0b", want.last, last_char_o));
        end
      end
    end
  end

  // Receiver: stall on its own pattern; a hold request keeps it stalled for a counted stretch.
  initial begin : receiver
    int n;
    int phase;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        n        = hold_req;
        hold_req = 0;
        stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        stall_i <= 1'b0;
      end else begin
        phase = (phase + 1) % 8;
        case (rx_mode)
          RX_FREE:     stall_i <= 1'b0;
          RX_LIGHT:    stall_i <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:    stall_i <= ($urandom_range(0, 9) < 7);
          RX_PERIODIC: stall_i <= (phase < 3);
          default:     stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Offer one value, after an optional idle gap, and hold it until the transaction completes.
  task automatic send_value(input logic [31:0] v);
    int gap;
    gap = 0;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, tx_max_gap);
        burst_left = $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (!(valid_i && !stall_o));
    push_decimal_text(v);
  endtask

  // Drop valid, then wait for every expected char plus the block's drain time.
  task automatic wait_idle();
    valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pow10(input int k);
    logic [31:0] p;
    p = 32'd1;
    repeat (k) p = p * 32'd10;
    return p;
  endfunction

  // Random value: full range, a chosen digit count, near powers of ten, or near the extremes.
  function automatic logic [31:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     n;
    bit     neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        n   = $urandom_range(1, 10);
        lo  = (n == 1) ? 0 : longint'(pow10(n - 1));
        hi  = (n == 10) ? (neg ? 64'd2147483648 : 64'd2147483647) : longint'(pow10(n)) - 1;
        mag = lo + (longint'($urandom) % (hi - lo + 1));
      end
      2: mag = longint'(pow10($urandom_range(0, 9))) + $urandom_range(0, 2) - 1;
      default: begin
        return neg ? 32'h8000_0000 + $urandom_range(0, 15)
                   : 32'h7FFF_FFFF - $urandom_range(0, 15);
      end
    endcase
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  task automatic test_directed();
    logic [31:0] vals[$];
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             32'd999999999, 32'd1234567890, -32'sd1234567890, 32'h5555_5555,
             32'hAAAA_AAAA, 32'd7, -32'sd9, 32'd1000000009, -32'sd100000};
    rx_mode = RX_FREE;
    tx_gaps = 1'b0;
    foreach (vals[i]) send_value(vals[i]);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 120; i++) begin
      // Change idling behavior on both sides every 25 transactions.
      if (i % 25 == 0) begin
        rx_mode    = rx_mode_e'($urandom_range(0, 3));
        tx_gaps    = ($urandom_range(0, 3) != 0);
        tx_max_gap = $urandom_range(1, 60);
      end
      send_value(random_value());
    end
    wait_idle();
  endtask

  task automatic test_back_pressure();
    rx_mode  = RX_FREE;
    tx_gaps  = 1'b0;
    hold_req = 300;
    for (int i = 0; i < 10; i++) send_value(random_value());
    wait_idle();
  endtask

  initial begin : main
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_back_pressure();
    if (mismatch_cnt == 0 && pending_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
